[rtl/ntsg_pkg.sv]
package ntsg_pkg;

	localparam int CfgWidth = 16;
	localparam int CfgIndexWidth = 3;

	localparam logic [CfgIndexWidth-1:0] REG_LINE_TOP     = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_NORMAL_PULSE = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_SHORT_PULSE  = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_BROAD_PULSE  = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_ACTIVE_LINES = 3'd4;

	localparam logic [15:0] RST_LINE_TOP     = 16'd1832;
	localparam logic [15:0] RST_NORMAL_PULSE = 16'd128;
	localparam logic [15:0] RST_SHORT_PULSE  = 16'd64;
	localparam logic [15:0] RST_BROAD_PULSE  = 16'd774;
	localparam logic [7:0]  RST_ACTIVE_LINES = 8'd243;

	localparam logic [15:0] START_PULSE = 16'd500;

	localparam logic [3:0] LVL_SYNC  = 4'h0;
	localparam logic [3:0] LVL_BLANK = 4'h3;
	localparam logic [3:0] LVL_DEBUG = 4'hF;

	localparam logic [4:0] VB_BROAD  = 5'd7;
	localparam logic [4:0] VB_SHORT  = 5'd13;
	localparam logic [4:0] VB_NORMAL = 5'd19;
	localparam logic [4:0] VB_END    = 5'd29;
	localparam logic [4:0] VB_LAST   = 5'd28;

	typedef enum logic [1:0] {
		SEL_START  = 2'd0,
		SEL_NORMAL = 2'd1,
		SEL_SHORT  = 2'd2,
		SEL_BROAD  = 2'd3
	} pulse_sel_t;

	typedef struct packed {
		logic [15:0] line_top;
		logic [15:0] normal_pulse;
		logic [15:0] short_pulse;
		logic [15:0] broad_pulse;
		logic [7:0]  active_lines;
	} cfg_t;

	typedef struct packed {
		logic [3:0] level;
		logic       line_start;
		logic       pulse_end;
		logic       in_vblank;
		logic [4:0] vblank_line;
		logic [7:0] picture_line;
		logic       active_video;
	} result_t;

endpackage

[rtl/ntsg_cfg.sv]
module ntsg_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ntsg_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [ntsg_pkg::CfgWidth-1:0]       cfg_wdata,
	output ntsg_pkg::cfg_t                      cfg
);

	ntsg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_top     <= ntsg_pkg::RST_LINE_TOP;
			cfg_q.normal_pulse <= ntsg_pkg::RST_NORMAL_PULSE;
			cfg_q.short_pulse  <= ntsg_pkg::RST_SHORT_PULSE;
			cfg_q.broad_pulse  <= ntsg_pkg::RST_BROAD_PULSE;
			cfg_q.active_lines <= ntsg_pkg::RST_ACTIVE_LINES;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ntsg_pkg::REG_LINE_TOP:     cfg_q.line_top     <= cfg_wdata;
				ntsg_pkg::REG_NORMAL_PULSE: cfg_q.normal_pulse <= cfg_wdata;
				ntsg_pkg::REG_SHORT_PULSE:  cfg_q.short_pulse  <= cfg_wdata;
				ntsg_pkg::REG_BROAD_PULSE:  cfg_q.broad_pulse  <= cfg_wdata;
				ntsg_pkg::REG_ACTIVE_LINES: cfg_q.active_lines <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/ntsg_core.sv]
module ntsg_core #(
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic                advance,
	input  ntsg_pkg::cfg_t      cfg,
	output ntsg_pkg::result_t   result
);

	localparam int CmpWidth = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic [TIMER_BITS-1:0]  tick_q, tick_n;
	logic                   half_q, half_n;
	ntsg_pkg::pulse_sel_t   sel_q, sel_n;
	logic [4:0]             vb_q, vb_n, vb_inc;
	logic [7:0]             line_q, line_n;
	logic [3:0]             level_q, level_n;

	logic [15:0]            top16, pulse16;
	logic [CmpWidth-1:0]    top_cmp, pulse_cmp, tick_cmp, tick_n_cmp;
	logic                   top_hit, pulse_hit;

	always_comb begin
		top16 = half_q ? {1'b0, cfg.line_top[15:1]} : cfg.line_top;
		case (sel_q)
			ntsg_pkg::SEL_NORMAL: pulse16 = cfg.normal_pulse;
			ntsg_pkg::SEL_SHORT:  pulse16 = cfg.short_pulse;
			ntsg_pkg::SEL_BROAD:  pulse16 = cfg.broad_pulse;
			default:              pulse16 = ntsg_pkg::START_PULSE;
		endcase
	end

	assign top_cmp    = CmpWidth'(top16);
	assign pulse_cmp  = CmpWidth'(pulse16);
	assign tick_cmp   = CmpWidth'(tick_q);
	assign tick_n     = (tick_cmp == top_cmp) ? '0 : tick_q + 1'b1;
	assign tick_n_cmp = CmpWidth'(tick_n);
	assign top_hit    = advance && (tick_n_cmp == top_cmp);
	assign pulse_hit  = advance && (tick_n_cmp == pulse_cmp);
	assign vb_inc     = vb_q + 5'd1;

	always_comb begin
		half_n  = half_q;
		sel_n   = sel_q;
		vb_n    = vb_q;
		line_n  = line_q;
		level_n = level_q;
		if (top_hit) begin
			level_n = ntsg_pkg::LVL_SYNC;
			if (vb_q != 5'd0) begin
				vb_n = vb_inc;
				if (vb_inc == ntsg_pkg::VB_BROAD) begin
					sel_n = ntsg_pkg::SEL_BROAD;
				end else if (vb_inc == ntsg_pkg::VB_SHORT) begin
					sel_n = ntsg_pkg::SEL_SHORT;
				end else if (vb_inc == ntsg_pkg::VB_NORMAL) begin
					half_n = 1'b0;
					sel_n  = ntsg_pkg::SEL_NORMAL;
				end else if (vb_inc == ntsg_pkg::VB_END) begin
					vb_n   = 5'd0;
					line_n = 8'd1;
				end
			end else if (line_q == cfg.active_lines) begin
				vb_n   = 5'd1;
				line_n = 8'd0;
				half_n = 1'b1;
				sel_n  = ntsg_pkg::SEL_SHORT;
			end else begin
				line_n = line_q + 8'd1;
			end
		end
		if (pulse_hit) begin
			level_n = ntsg_pkg::LVL_BLANK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			half_q  <= 1'b0;
			sel_q   <= ntsg_pkg::SEL_START;
			vb_q    <= 5'd0;
			line_q  <= 8'd0;
			level_q <= ntsg_pkg::LVL_DEBUG;
		end else if (step_en && advance) begin
			tick_q  <= tick_n;
			half_q  <= half_n;
			sel_q   <= sel_n;
			vb_q    <= vb_n;
			line_q  <= line_n;
			level_q <= level_n;
		end
	end

	always_comb begin
		result.level        = level_n;
		result.line_start   = top_hit;
		result.pulse_end    = pulse_hit;
		result.in_vblank    = (vb_n != 5'd0);
		result.vblank_line  = vb_n;
		result.picture_line = line_n;
		result.active_video = (vb_n == 5'd0) && (level_n == ntsg_pkg::LVL_BLANK);
	end

endmodule

[rtl/ntsc_sync_timing_generator.sv]
// NTSC 240p sync timing generator. Each accepted transaction is one timer tick
// (advance=1) or a status query (advance=0), and produces exactly one result.
// One transaction is taken every cycle unless in_stall is raised. A result is presented
// once its transaction has passed an input register, then the output register fed by
// the combinational timing state update. The tick counter within a line is TIMER_BITS
// wide and compares against the 16-bit line top, halved in the short- and broad-pulse lines of the vertical sequence.
// Configuration registers should be written only while no transaction is in flight.
module ntsc_sync_timing_generator #(
	parameter int TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ntsg_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [ntsg_pkg::CfgWidth-1:0]       cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                advance,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [3:0]                          level,
	output logic                                line_start,
	output logic                                pulse_end,
	output logic                                in_vblank,
	output logic [4:0]                          vblank_line,
	output logic [7:0]                          picture_line,
	output logic                                active_video
);

	ntsg_pkg::cfg_t     cfg;
	ntsg_pkg::result_t  core_res;
	ntsg_pkg::result_t  res_s2;

	logic valid_s1, advance_s1, valid_s2;
	logic s2_load, s1_move, in_accept;

	ntsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ntsg_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (s1_move),
		.advance (advance_s1),
		.cfg     (cfg),
		.result  (core_res)
	);

	assign s2_load   = !valid_s2 || !out_stall;
	assign s1_move   = valid_s1 && s2_load;
	assign in_stall  = valid_s1 && !s2_load;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			advance_s1 <= advance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2 <= core_res;
		end
	end

	assign out_valid    = valid_s2;
	assign level        = res_s2.level;
	assign line_start   = res_s2.line_start;
	assign pulse_end    = res_s2.pulse_end;
	assign in_vblank    = res_s2.in_vblank;
	assign vblank_line  = res_s2.vblank_line;
	assign picture_line = res_s2.picture_line;
	assign active_video = res_s2.active_video;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_end |-> level == ntsg_pkg::LVL_BLANK)
		else $error("pulse end without blank level");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_start && !pulse_end |-> level == ntsg_pkg::LVL_SYNC)
		else $error("line start without sync level");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(in_vblank && picture_line != 8'd0))
		else $error("picture line counting during vertical sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vblank_line <= ntsg_pkg::VB_LAST)
		else $error("vertical sequence counter out of range");

endmodule
